### design/gtes_pkg.sv
// ----------------------------------------------------------------------------
// gtes_pkg: shared types and constants for the greedy tour edge selector
// Word layouts, sequencer states, memory command struct, degree helper.
// ----------------------------------------------------------------------------
package gtes_pkg;

    localparam int CITY_W       = 5;
    localparam int LEN_W        = 32;
    localparam int CFG_W        = 6;
    localparam int DEG_W        = 2;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 56;
    localparam int OUT_FIELDS_W = 1 + CITY_W + 1 + 1 + CITY_W + CITY_W + LEN_W;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
    localparam int IN_PAD_W     = IN_TDATA_W - (2 * CITY_W + LEN_W);

    localparam int DEF_MAX_CITIES = 32;
    localparam int MIN_CITIES     = 3;

    localparam logic [CFG_W-1:0] NUM_CITIES_RST = 6'd32;
    localparam logic [DEG_W-1:0] DEG_FULL       = 2'd2;
    localparam logic [DEG_W-1:0] DEG_SAT        = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK_A,
        ST_WALK_B,
        ST_DECIDE,
        ST_UPD_B,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              new_problem;
        logic [CITY_W-1:0] edge_from;
        logic [CITY_W-1:0] edge_to;
        logic [LEN_W-1:0]  edge_length;
    } edge_t;

    typedef struct packed {
        logic              accepted;
        logic [CITY_W-1:0] tour_slot;
        logic              closing_edge;
        logic              tour_complete;
        logic [CITY_W-1:0] out_from;
        logic [CITY_W-1:0] out_to;
        logic [LEN_W-1:0]  out_length;
    } result_t;

    typedef struct packed {
        logic wr_en;
        logic clear;
    } mem_cmd_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

    // add one (or two for a self loop) to a degree, saturating
    function automatic logic [DEG_W-1:0] deg_bump(input logic [DEG_W-1:0] d,
                                                  input logic twice);
        logic [DEG_W:0] s;
        s = {1'b0, d} + (twice ? 3'd2 : 3'd1);
        return (s > {1'b0, DEG_SAT}) ? DEG_SAT : s[DEG_W-1:0];
    endfunction

endpackage

### design/gtes_parent_ram.sv
// ----------------------------------------------------------------------------
// gtes_parent_ram: union-find parent memory
// One write and one registered read port; an unwritten entry reads as its
// own index (each city its own root). Clear drops all valid bits at once.
// ----------------------------------------------------------------------------
module gtes_parent_ram
    import gtes_pkg::*;
#(
    parameter int MAX_CITIES = DEF_MAX_CITIES,
    localparam int IW        = $clog2(MAX_CITIES)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  mem_cmd_t      cmd,
    input  logic [IW-1:0] wr_addr,
    input  logic [IW-1:0] wr_data,
    input  logic [IW-1:0] rd_addr,
    output logic [IW-1:0] rd_data
);

    logic [IW-1:0]         mem [MAX_CITIES];
    logic [MAX_CITIES-1:0] valid_reg;
    logic [IW-1:0]         rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.clear)
        begin
            valid_reg <= '0;
        end
        else if (cmd.wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= valid_reg[rd_addr] ? mem[rd_addr] : rd_addr;
    end

    assign rd_data = rdata_reg;

endmodule

### design/gtes_degree_ram.sv
// ----------------------------------------------------------------------------
// gtes_degree_ram: per-city tour degree memory
// One write and one registered read port; an unwritten entry reads as zero.
// ----------------------------------------------------------------------------
module gtes_degree_ram
    import gtes_pkg::*;
#(
    parameter int MAX_CITIES = DEF_MAX_CITIES,
    localparam int IW        = $clog2(MAX_CITIES)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  mem_cmd_t         cmd,
    input  logic [IW-1:0]    wr_addr,
    input  logic [DEG_W-1:0] wr_data,
    input  logic [IW-1:0]    rd_addr,
    output logic [DEG_W-1:0] rd_data
);

    logic [DEG_W-1:0]      mem [MAX_CITIES];
    logic [MAX_CITIES-1:0] valid_reg;
    logic [DEG_W-1:0]      rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.clear)
        begin
            valid_reg <= '0;
        end
        else if (cmd.wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

    assign rd_data = rdata_reg;

endmodule

### design/gtes_seq.sv
// ----------------------------------------------------------------------------
// gtes_seq: edge sequencer
// Walks both endpoints to their roots one parent read per cycle, then
// decides acceptance and writes back degrees and the root link.
// ----------------------------------------------------------------------------
module gtes_seq
    import gtes_pkg::*;
#(
    parameter int MAX_CITIES = DEF_MAX_CITIES,
    localparam int IW        = $clog2(MAX_CITIES),
    localparam int SW        = $clog2(MAX_CITIES),
    localparam int CNT_W     = $clog2(MAX_CITIES + 1),
    localparam int NW        = (CNT_W > CFG_W) ? CNT_W : CFG_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] num_cities,
    input  logic             in_valid,
    output logic             in_ready,
    input  edge_t            in_edge,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res,
    output seq_stat_t        stat,
    output mem_cmd_t         p_cmd,
    output logic [IW-1:0]    p_wr_addr,
    output logic [IW-1:0]    p_wr_data,
    output logic [IW-1:0]    p_rd_addr,
    input  logic [IW-1:0]    p_rd_data,
    output mem_cmd_t         d_cmd,
    output logic [IW-1:0]    d_wr_addr,
    output logic [DEG_W-1:0] d_wr_data,
    output logic [IW-1:0]    d_rd_addr,
    input  logic [DEG_W-1:0] d_rd_data
);

    state_t            state_reg,   state_next;
    logic [NW-1:0]     taken_reg,   taken_next;
    logic              done_reg,    done_next;
    logic [CITY_W-1:0] a_reg,       a_next;
    logic [CITY_W-1:0] b_reg,       b_next;
    logic [LEN_W-1:0]  len_reg,     len_next;
    logic [IW-1:0]     cur_reg,     cur_next;
    logic [SW-1:0]     steps_reg,   steps_next;
    logic [IW-1:0]     ra_reg,      ra_next;
    logic [IW-1:0]     rb_reg,      rb_next;
    logic [DEG_W-1:0]  deg_a_reg,   deg_a_next;
    logic [DEG_W-1:0]  deg_b_reg,   deg_b_next;
    logic              acc_reg,     acc_next;
    logic              closing_reg, closing_next;
    logic [CITY_W-1:0] slot_reg,    slot_next;

    logic [NW-1:0] cfg_ext;
    logic [NW-1:0] n_eff;
    logic [NW-1:0] n_minus_1;
    logic          in_range;
    logic          root_found;
    logic          free_deg;
    logic          below;
    logic          take;
    logic [IW-1:0] a_idx;
    logic [IW-1:0] b_idx;

    assign cfg_ext   = NW'(num_cities);
    assign n_eff     = (cfg_ext < NW'(MIN_CITIES)) ? NW'(MIN_CITIES) :
                       (cfg_ext > NW'(MAX_CITIES)) ? NW'(MAX_CITIES) : cfg_ext;
    assign n_minus_1 = n_eff - NW'(1);
    assign in_range  = (NW'(a_reg) < n_eff) && (NW'(b_reg) < n_eff);
    assign a_idx     = IW'(a_reg);
    assign b_idx     = IW'(b_reg);

    // walk ends on a self-parent or after the step bound
    assign root_found = (p_rd_data == cur_reg) || (steps_reg == SW'(MAX_CITIES - 1));

    assign free_deg = (deg_a_reg < DEG_FULL) && (deg_b_reg < DEG_FULL);
    assign below    = taken_reg < n_minus_1;
    assign take     = free_deg && (below ? (ra_reg != rb_reg) : (ra_reg == rb_reg));

    always_comb
    begin
        state_next   = state_reg;
        taken_next   = taken_reg;
        done_next    = done_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        len_next     = len_reg;
        cur_next     = cur_reg;
        steps_next   = steps_reg;
        ra_next      = ra_reg;
        rb_next      = rb_reg;
        deg_a_next   = deg_a_reg;
        deg_b_next   = deg_b_reg;
        acc_next     = acc_reg;
        closing_next = closing_reg;
        slot_next    = slot_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        p_cmd        = '0;
        d_cmd        = '0;
        p_wr_addr    = rb_reg;
        p_wr_data    = ra_reg;
        p_rd_addr    = cur_reg;
        d_wr_addr    = a_idx;
        d_wr_data    = deg_bump(deg_a_reg, a_reg == b_reg);
        d_rd_addr    = a_idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    a_next   = in_edge.edge_from;
                    b_next   = in_edge.edge_to;
                    len_next = in_edge.edge_length;
                    if (in_edge.new_problem)
                    begin
                        p_cmd.clear = 1'b1;
                        d_cmd.clear = 1'b1;
                        taken_next  = '0;
                        done_next   = 1'b0;
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                acc_next     = 1'b0;
                closing_next = 1'b0;
                slot_next    = '0;
                if (done_reg || !in_range)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cur_next   = a_idx;
                    steps_next = '0;
                    p_rd_addr  = a_idx;
                    d_rd_addr  = a_idx;
                    state_next = ST_WALK_A;
                end
            end
            ST_WALK_A:
            begin
                if (root_found)
                begin
                    ra_next    = p_rd_data;
                    deg_a_next = d_rd_data;
                    cur_next   = b_idx;
                    steps_next = '0;
                    p_rd_addr  = b_idx;
                    d_rd_addr  = b_idx;
                    state_next = ST_WALK_B;
                end
                else
                begin
                    cur_next   = p_rd_data;
                    steps_next = steps_reg + SW'(1);
                    p_rd_addr  = p_rd_data;
                end
            end
            ST_WALK_B:
            begin
                d_rd_addr = b_idx;
                if (root_found)
                begin
                    rb_next    = p_rd_data;
                    deg_b_next = d_rd_data;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cur_next   = p_rd_data;
                    steps_next = steps_reg + SW'(1);
                    p_rd_addr  = p_rd_data;
                end
            end
            ST_DECIDE:
            begin
                if (take)
                begin
                    acc_next     = 1'b1;
                    closing_next = !below;
                    d_cmd.wr_en  = 1'b1;
                    if (below)
                    begin
                        slot_next   = taken_reg[CITY_W-1:0];
                        taken_next  = taken_reg + NW'(1);
                        p_cmd.wr_en = 1'b1;
                    end
                    else
                    begin
                        slot_next = n_minus_1[CITY_W-1:0];
                        done_next = 1'b1;
                    end
                    state_next = (a_reg != b_reg) ? ST_UPD_B : ST_FINISH;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_UPD_B:
            begin
                d_cmd.wr_en = 1'b1;
                d_wr_addr   = b_idx;
                d_wr_data   = deg_bump(deg_b_reg, 1'b0);
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                res_valid = res_ready;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            taken_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            taken_reg <= taken_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        len_reg     <= len_next;
        cur_reg     <= cur_next;
        steps_reg   <= steps_next;
        ra_reg      <= ra_next;
        rb_reg      <= rb_next;
        deg_a_reg   <= deg_a_next;
        deg_b_reg   <= deg_b_next;
        acc_reg     <= acc_next;
        closing_reg <= closing_next;
        slot_reg    <= slot_next;
    end

    assign res.accepted      = acc_reg;
    assign res.tour_slot     = slot_reg;
    assign res.closing_edge  = closing_reg;
    assign res.tour_complete = done_reg;
    assign res.out_from      = a_reg;
    assign res.out_to        = b_reg;
    assign res.out_length    = len_reg;

    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.done = done_reg;

endmodule

### design/greedy_tour_edge_selector.sv
// ----------------------------------------------------------------------------
// greedy_tour_edge_selector: greedy-edge tour builder
// Takes edges sorted by length and says which ones join the tour.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one edge per word; s_axis_tuser[0] = new_problem clears the
//   forest, degrees, taken count and done flag before that edge is handled.
//   m_axis returns one result word per edge, in order.
//   cfg_valid/cfg_data writes num_cities (clamped to 3..MAX_CITIES in use);
//   cfg_ready is always high. Write it only while the block is idle.
// Sequence:
//   Each edge passes CHECK, WALK_A, WALK_B, DECIDE, then UPD_B (only for an
//   accepted edge with distinct endpoints) and FINISH; the root walks take
//   1..MAX_CITIES steps each, as the parent memory's single read port is
//   visited once per step. Rejected out-of-range or post-completion edges
//   go from CHECK straight to FINISH. s_axis_tready is high only while the
//   sequencer is idle.
// Reset / stall:
//   Reset puts every city in its own tree with degree zero, num_cities to 32.
//   The result sits in an output register; a new edge may be taken while it
//   waits, but that edge's result holds until m_axis_tready frees the slot.
// ----------------------------------------------------------------------------
module greedy_tour_edge_selector
    import gtes_pkg::*;
#(
    parameter int MAX_CITIES = DEF_MAX_CITIES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       cfg_data,       // num_cities
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // edge_from, edge_to, edge_length, pad
    input  logic [0:0]             s_axis_tuser,   // new_problem
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // accepted, tour_slot, closing_edge,
                                                   // tour_complete, out_from, out_to,
                                                   // out_length, pad
);

    localparam int IW = $clog2(MAX_CITIES);

    logic [CFG_W-1:0] num_cities_reg;
    logic             out_valid_reg;
    result_t          out_word_reg;

    edge_t            in_edge;
    result_t          res;
    logic             res_valid;
    logic             res_ready;
    seq_stat_t        stat;
    mem_cmd_t         p_cmd;
    logic [IW-1:0]    p_wr_addr;
    logic [IW-1:0]    p_wr_data;
    logic [IW-1:0]    p_rd_addr;
    logic [IW-1:0]    p_rd_data;
    mem_cmd_t         d_cmd;
    logic [IW-1:0]    d_wr_addr;
    logic [DEG_W-1:0] d_wr_data;
    logic [IW-1:0]    d_rd_addr;
    logic [DEG_W-1:0] d_rd_data;
    logic             seq_in_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cities_reg <= NUM_CITIES_RST;
        end
        else if (cfg_valid)
        begin
            num_cities_reg <= cfg_data;
        end
    end

    assign in_edge.new_problem = s_axis_tuser[0];
    assign in_edge.edge_from   = s_axis_tdata[CITY_W-1:0];
    assign in_edge.edge_to     = s_axis_tdata[2*CITY_W-1:CITY_W];
    assign in_edge.edge_length = s_axis_tdata[2*CITY_W+LEN_W-1:2*CITY_W];

    gtes_parent_ram #(
        .MAX_CITIES (MAX_CITIES)
    ) u_parent (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (p_cmd),
        .wr_addr (p_wr_addr),
        .wr_data (p_wr_data),
        .rd_addr (p_rd_addr),
        .rd_data (p_rd_data)
    );

    gtes_degree_ram #(
        .MAX_CITIES (MAX_CITIES)
    ) u_degree (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (d_cmd),
        .wr_addr (d_wr_addr),
        .wr_data (d_wr_data),
        .rd_addr (d_rd_addr),
        .rd_data (d_rd_data)
    );

    gtes_seq #(
        .MAX_CITIES (MAX_CITIES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .num_cities (num_cities_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (seq_in_ready),
        .in_edge    (in_edge),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .stat       (stat),
        .p_cmd      (p_cmd),
        .p_wr_addr  (p_wr_addr),
        .p_wr_data  (p_wr_data),
        .p_rd_addr  (p_rd_addr),
        .p_rd_data  (p_rd_data),
        .d_cmd      (d_cmd),
        .d_wr_addr  (d_wr_addr),
        .d_wr_data  (d_wr_data),
        .d_rd_addr  (d_rd_addr),
        .d_rd_data  (d_rd_data)
    );

    assign s_axis_tready = seq_in_ready;

    // output slot is free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_word_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}},
                            out_word_reg.out_length,
                            out_word_reg.out_to,
                            out_word_reg.out_from,
                            out_word_reg.tour_complete,
                            out_word_reg.closing_edge,
                            out_word_reg.tour_slot,
                            out_word_reg.accepted};

    // every return to idle hands exactly one result to the output register
    a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stat.idle) |-> $past(res_valid))
        else $error("sequencer went idle without delivering a result");

    // done flag only drops on an accepted new_problem word
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.done && !(s_axis_tvalid && s_axis_tready && s_axis_tuser[0]))
        |=> stat.done)
        else $error("tour done flag dropped without a new problem");

    // a closing edge is always an accepted edge that completes the tour
    a_closing_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_word_reg.closing_edge)
        |-> (out_word_reg.accepted && out_word_reg.tour_complete))
        else $error("closing edge word without accept or completion");

endmodule

### tb/sv/tb_greedy_tour_edge_selector.sv
// ----------------------------------------------------------------------------
// tb_greedy_tour_edge_selector: self-checking bench for the greedy tour selector
// Streams sorted edge sets through s_axis, mirrors the union-find forest and
// degree counters in a local predictor and checks every m_axis result word.
// ----------------------------------------------------------------------------
module tb_greedy_tour_edge_selector
    import gtes_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CITIES      = DEF_MAX_CITIES;
    localparam int ITEM_TARGET = 1450;
    localparam int DRAIN_WAIT  = 2 * CITIES + 16;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // edge_from, edge_to, edge_length, pad
    logic [0:0]             s_axis_tuser = '0;   // new_problem
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;       // accepted, tour_slot, closing_edge,
                                                // tour_complete, out_from, out_to,
                                                // out_length, pad

    greedy_tour_edge_selector u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor state
    // ------------------------------------------------------------------
    logic [CITY_W-1:0] tree_up [CITIES];
    logic [DEG_W-1:0]  tour_deg [CITIES];
    logic [5:0]        edges_taken;
    logic              tour_closed;
    logic [CFG_W-1:0]  cities_cfg;

    edge_t   pending_edges [$];
    result_t expected_verdicts [$];
    int      mismatch_count = 0;
    int      cfg_write_count = 0;
    int      edges_queued = 0;
    logic    in_fire = 1'b0;

    function automatic void clear_forest();
        for (int i = 0; i < CITIES; i++)
        begin
            tree_up[i]  = CITY_W'(i);
            tour_deg[i] = '0;
        end
        edges_taken = '0;
        tour_closed = 1'b0;
    endfunction

    // bounded walk, no path compression
    function automatic logic [CITY_W-1:0] walk_to_root(input logic [CITY_W-1:0] c);
        logic settled;
        settled = 1'b0;
        for (int s = 0; s < CITIES; s++)
        begin
            if (!settled)
            begin
                if (tree_up[c] == c)
                    settled = 1'b1;
                else
                    c = tree_up[c];
            end
        end
        return c;
    endfunction

    function automatic void bump_degree(input logic [CITY_W-1:0] c);
        if (tour_deg[c] < DEG_SAT)
            tour_deg[c] = tour_deg[c] + 2'd1;
    endfunction

    task automatic predict_edge(input edge_t e, output result_t r);
        int                n;
        logic [CITY_W-1:0] ra;
        logic [CITY_W-1:0] rb;
        logic              free_deg;
        n = int'(cities_cfg);
        if (n < MIN_CITIES)
            n = MIN_CITIES;
        if (n > CITIES)
            n = CITIES;
        r = '0;
        r.out_from   = e.edge_from;
        r.out_to     = e.edge_to;
        r.out_length = e.edge_length;
        if (e.new_problem)
            clear_forest();
        if (!tour_closed && int'(e.edge_from) < n && int'(e.edge_to) < n)
        begin
            ra = walk_to_root(e.edge_from);
            rb = walk_to_root(e.edge_to);
            free_deg = (tour_deg[e.edge_from] < DEG_FULL) && (tour_deg[e.edge_to] < DEG_FULL);
            if (int'(edges_taken) < n - 1)
            begin
                if (free_deg && ra != rb)
                begin
                    r.accepted  = 1'b1;
                    r.tour_slot = edges_taken[CITY_W-1:0];
                    edges_taken = edges_taken + 6'd1;
                    bump_degree(e.edge_from);
                    bump_degree(e.edge_to);
                    tree_up[rb] = ra;
                end
            end
            else if (free_deg && ra == rb)
            begin
                // closing edge; a self loop lands here and takes two degrees
                r.accepted     = 1'b1;
                r.closing_edge = 1'b1;
                r.tour_slot    = CITY_W'(n - 1);
                bump_degree(e.edge_from);
                bump_degree(e.edge_to);
                tour_closed = 1'b1;
            end
        end
        r.tour_complete = tour_closed;
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_mismatch(what, got, want);
    endtask

    // ------------------------------------------------------------------
    // monitor: config, results, accepted edges (results first so a word
    // leaving in the same cycle matches the older edge)
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        result_t want;
        result_t got;
        edge_t   e;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                cities_cfg = cfg_data;
                cfg_write_count++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.accepted      = m_axis_tdata[0];
                got.tour_slot     = m_axis_tdata[5:1];
                got.closing_edge  = m_axis_tdata[6];
                got.tour_complete = m_axis_tdata[7];
                got.out_from      = m_axis_tdata[12:8];
                got.out_to        = m_axis_tdata[17:13];
                got.out_length    = m_axis_tdata[49:18];
                if (expected_verdicts.size() == 0)
                    flag_mismatch("result word with no pending edge", 32'(got.out_from), 0);
                else
                begin
                    want = expected_verdicts.pop_front();
                    check_field("accepted", 32'(got.accepted), 32'(want.accepted));
                    check_field("tour_slot", 32'(got.tour_slot), 32'(want.tour_slot));
                    check_field("closing_edge", 32'(got.closing_edge), 32'(want.closing_edge));
                    check_field("tour_complete", 32'(got.tour_complete),
                                32'(want.tour_complete));
                    check_field("out_from", 32'(got.out_from), 32'(want.out_from));
                    check_field("out_to", 32'(got.out_to), 32'(want.out_to));
                    check_field("out_length", got.out_length, want.out_length);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                e.new_problem = s_axis_tuser[0];
                e.edge_from   = s_axis_tdata[4:0];
                e.edge_to     = s_axis_tdata[9:5];
                e.edge_length = s_axis_tdata[41:10];
                predict_edge(e, want);
                expected_verdicts.push_back(want);
            end
            in_fire <= s_axis_tvalid && s_axis_tready;
        end
        else
            in_fire <= 1'b0;
    end

    // ------------------------------------------------------------------
    // driver: bursts of words with random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin : driver
        logic  nv;
        edge_t item;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            nv = s_axis_tvalid;
            if (s_axis_tvalid && in_fire)
                nv = 1'b0;
            if (!nv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_edges.size() > 0)
                begin
                    item = pending_edges.pop_front();
                    s_axis_tdata <= {{IN_PAD_W{1'b0}}, item.edge_length, item.edge_to,
                                     item.edge_from};
                    s_axis_tuser <= item.new_problem;
                    nv = 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left--;
                end
            end
            s_axis_tvalid <= nv;
        end
    end

    // receiver stalls: stretches of always-ready, coin-flip and sparse ready
    int stall_mode = 0;
    int stall_timer = 0;

    always @(negedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode  = $urandom_range(0, 2);
            stall_timer = $urandom_range(20, 300);
        end
        else
            stall_timer--;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic push_edge(input logic newp, input int a, input int b,
                             input logic [31:0] len);
        edge_t e;
        e.new_problem = newp;
        e.edge_from   = CITY_W'(a);
        e.edge_to     = CITY_W'(b);
        e.edge_length = len;
        pending_edges.push_back(e);
        edges_queued++;
    endtask

    task automatic push_noise();
        push_edge($urandom_range(0, 3) == 0, $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom);
    endtask

    task automatic write_cities(input logic [CFG_W-1:0] v);
        int seen;
        seen = cfg_write_count;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(negedge clk);
        while (cfg_write_count == seen);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_edges.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // one problem: complete graph for few cities, else a hidden cycle plus
    // random chords; ascending lengths, sometimes cut short or salted
    task automatic queue_tour_problem(input int n);
        int          pa [128];
        int          pb [128];
        int          perm [CITIES];
        int          cnt;
        int          j;
        int          t;
        int          stop_at;
        logic [31:0] len;
        cnt = 0;
        if (n <= 9)
        begin
            for (int a = 0; a < n; a++)
                for (int b = a + 1; b < n; b++)
                begin
                    pa[cnt] = a;
                    pb[cnt] = b;
                    cnt++;
                end
        end
        else
        begin
            for (int i = 0; i < n; i++)
                perm[i] = i;
            for (int i = n - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                t = perm[i];
                perm[i] = perm[j];
                perm[j] = t;
            end
            for (int i = 0; i < n; i++)
            begin
                pa[cnt] = perm[i];
                pb[cnt] = perm[(i + 1) % n];
                cnt++;
            end
            for (int k = 0; k < 2 * n; k++)
            begin
                pa[cnt] = $urandom_range(0, n - 1);
                pb[cnt] = $urandom_range(0, n - 1);
                cnt++;
            end
        end
        for (int i = cnt - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = pa[i];
            pa[i] = pa[j];
            pa[j] = t;
            t = pb[i];
            pb[i] = pb[j];
            pb[j] = t;
        end
        stop_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, cnt) : cnt;
        len = $urandom_range(0, 1 << 16);
        for (int k = 0; k < stop_at; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                push_noise();
            if ($urandom_range(0, 1) == 0)
                push_edge(k == 0, pa[k], pb[k], len);
            else
                push_edge(k == 0, pb[k], pa[k], len);
            len = len + $urandom_range(0, 1 << 17);
        end
    endtask

    initial
    begin : stimulus
        int          pick;
        int          n;
        logic [5:0]  cfg_val;
        clear_forest();
        cities_cfg = NUM_CITIES_RST;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // default 32 cities: extreme lengths, self loop, degree and cycle rejects
        push_edge(1'b1, 0, 1, 32'h0000_0000);
        push_edge(1'b0, 31, 30, 32'hFFFF_FFFF);
        push_edge(1'b0, 5, 5, 32'h0001_0000);
        push_edge(1'b0, 1, 2, 32'h0001_8000);
        push_edge(1'b0, 0, 3, 32'h0002_0000);
        push_edge(1'b0, 0, 4, 32'h0002_0001);
        push_edge(1'b0, 2, 3, 32'h0003_0000);
        wait_drained();

        // register below range acts as three cities
        write_cities(6'd0);
        push_edge(1'b1, 0, 1, 32'h0000_0100);
        push_edge(1'b0, 1, 3, 32'h0000_0200);
        push_edge(1'b0, 1, 2, 32'h0000_0300);
        push_edge(1'b0, 2, 0, 32'h0000_0400);
        push_edge(1'b0, 0, 1, 32'h0000_0500);
        // self loop first rejected, later closes the tour
        push_edge(1'b1, 0, 0, 32'h0000_0010);
        push_edge(1'b0, 0, 1, 32'h0000_0020);
        push_edge(1'b0, 1, 2, 32'h0000_0030);
        push_edge(1'b0, 0, 0, 32'h0000_0040);
        wait_drained();

        // above range acts as the full size; then shrink under the taken count
        write_cities(6'd63);
        push_edge(1'b1, 0, 1, 32'h0000_1000);
        push_edge(1'b0, 1, 2, 32'h0000_2000);
        push_edge(1'b0, 4, 5, 32'h0000_3000);
        wait_drained();
        write_cities(6'd3);
        push_edge(1'b0, 2, 0, 32'h0000_4000);
        push_edge(1'b0, 0, 1, 32'h0000_5000);
        wait_drained();

        while (edges_queued < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                cfg_val = 6'($urandom_range(0, 2));
            else if (pick == 1)
                cfg_val = 6'($urandom_range(32, 63));
            else if (pick == 2)
                cfg_val = 6'($urandom_range(11, 31));
            else
                cfg_val = 6'($urandom_range(3, 10));
            write_cities(cfg_val);
            n = int'(cfg_val);
            if (n < MIN_CITIES)
                n = MIN_CITIES;
            if (n > CITIES)
                n = CITIES;
            // leftover forest under the new size before the next clear
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 6)) push_noise();
            repeat ($urandom_range(1, 3)) queue_tour_problem(n);
            repeat ($urandom_range(0, 10)) push_noise();
            wait_drained();
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### greedy_tour_edge_selector.f
design/gtes_pkg.sv
design/gtes_parent_ram.sv
design/gtes_degree_ram.sv
design/gtes_seq.sv
design/greedy_tour_edge_selector.sv
tb/sv/tb_greedy_tour_edge_selector.sv
